// ===== design/qypr_pkg.sv =====
// shared types and constants for the quaternion to yaw, pitch and roll core
// no dependencies
package qypr_pkg;

  localparam int IN_W   = 16;   // quaternion component, signed q2.14
  localparam int YAW_W  = 16;   // yaw result, signed q3.13
  localparam int PR_W   = 15;   // pitch and roll results, signed q2.13
  localparam int PROD_W = 32;   // product of two components
  localparam int G_W    = 33;   // gravity components
  localparam int OP_W   = 34;   // yaw operands and cordic operands
  localparam int SQ_W   = 64;   // sum of two squares
  localparam int ROOT_W = SQ_W / 2;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int XW            = OP_W + 4;   // cordic x and y, room for gain
  localparam int ZW            = 36;         // angle accumulator, q.30 radians
  localparam int ANG_SHIFT     = 17;         // q.30 to q.13

  localparam int FRONT_LAT   = 4;
  localparam int FRONT_CNT_W = $clog2(FRONT_LAT + 1);
  localparam int Q_DEPTH     = 8;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic signed [YAW_W-1:0] PI_Q13      = YAW_W'(25736);
  localparam logic signed [YAW_W-1:0] HALF_PI_Q13 = YAW_W'(12868);
  localparam logic signed [OP_W-1:0]  ONE_Q28     = OP_W'(64'd268435456);
  localparam logic signed [ZW-1:0]    PI_Q30      = ZW'(64'd3373259426);
  localparam logic signed [ZW-1:0]    ROUND_BIAS  = ZW'(64'd65536);

  // atan(2^-i) in q.30, truncated except the first entry, which is rounded up
  localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
    ZW'(843314857), ZW'(497837829), ZW'(263043836), ZW'(133525158),
    ZW'(67021686),  ZW'(33543515),  ZW'(16775850),  ZW'(8388437),
    ZW'(4194282),   ZW'(2097149),   ZW'(1048575),   ZW'(524287),
    ZW'(262143),    ZW'(131071),    ZW'(65535),     ZW'(32767),
    ZW'(16383),     ZW'(8191),      ZW'(4095),      ZW'(2047),
    ZW'(1023),      ZW'(511),       ZW'(255),       ZW'(127)
  };

  // one classified item handed from the front to the back
  typedef struct packed {
    logic signed [OP_W-1:0] yaw_num;
    logic signed [OP_W-1:0] yaw_den;
    logic signed [G_W-1:0]  gx;
    logic signed [G_W-1:0]  gy;
    logic [SQ_W-1:0]        sum_p;
    logic [SQ_W-1:0]        sum_r;
  } qitem_t;

endpackage

// ===== design/qypr_front.sv =====
// front part: products, gravity vector, yaw operands and sums of squares
// depends on qypr_pkg; four register stages, never stalls
module qypr_front import qypr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic signed [IN_W-1:0] quat_w,
  input  logic signed [IN_W-1:0] quat_x,
  input  logic signed [IN_W-1:0] quat_y,
  input  logic signed [IN_W-1:0] quat_z,
  output logic                   push,
  output qitem_t                 item,
  output logic [FRONT_CNT_W-1:0] inflight
);

  logic [FRONT_LAT-1:0] v_r;

  // stage 1: component products
  logic signed [PROD_W-1:0] ww_r, xx_r, yy_r, zz_r, xz_r, wy_r, wx_r, yz_r, xy_r, wz_r;

  // stage 2: gravity and yaw operands
  logic signed [G_W-1:0]    gx2_r, gy2_r, gz2_r;
  logic signed [OP_W-1:0]   yn2_r, yd2_r;
  logic signed [G_W-1:0]    gx_nxt, gy_nxt, gz_nxt, ydiff, ysum;
  logic signed [G_W:0]      gz_sum;
  logic signed [OP_W-1:0]   yn_nxt, yd_nxt;

  // stage 3: squares
  logic signed [G_W-1:0]    gx3_r, gy3_r;
  logic signed [OP_W-1:0]   yn3_r, yd3_r;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic [ROOT_W-1:0]        mx, my, mz;
  logic [SQ_W-1:0]          sqx_nxt, sqy_nxt, sqz_nxt;

  // stage 4
  qitem_t                   item_r;

  function automatic logic [ROOT_W-1:0] mag(input logic signed [G_W-1:0] v);
    logic [G_W-1:0] m;
    m = v[G_W-1] ? G_W'(-v) : G_W'(v);
    return m[ROOT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    ww_r <= quat_w * quat_w;
    xx_r <= quat_x * quat_x;
    yy_r <= quat_y * quat_y;
    zz_r <= quat_z * quat_z;
    xz_r <= quat_x * quat_z;
    wy_r <= quat_w * quat_y;
    wx_r <= quat_w * quat_x;
    yz_r <= quat_y * quat_z;
    xy_r <= quat_x * quat_y;
    wz_r <= quat_w * quat_z;
  end

  always_comb begin
    gx_nxt = G_W'(xz_r) - G_W'(wy_r);
    gy_nxt = G_W'(wx_r) + G_W'(yz_r);
    gz_sum = (G_W+1)'(ww_r) - (G_W+1)'(xx_r) - (G_W+1)'(yy_r) + (G_W+1)'(zz_r);
    gz_nxt = G_W'(gz_sum >>> 1);
    ydiff  = G_W'(xy_r) - G_W'(wz_r);
    ysum   = G_W'(ww_r) + G_W'(xx_r);
    yn_nxt = $signed({ydiff, 1'b0});
    yd_nxt = $signed({ysum, 1'b0}) - ONE_Q28;
  end

  always_ff @(posedge clk) begin
    gx2_r <= gx_nxt;
    gy2_r <= gy_nxt;
    gz2_r <= gz_nxt;
    yn2_r <= yn_nxt;
    yd2_r <= yd_nxt;
  end

  always_comb begin
    mx      = mag(gx2_r);
    my      = mag(gy2_r);
    mz      = mag(gz2_r);
    sqx_nxt = mx * mx;
    sqy_nxt = my * my;
    sqz_nxt = mz * mz;
  end

  always_ff @(posedge clk) begin
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    sqz_r <= sqz_nxt;
    gx3_r <= gx2_r;
    gy3_r <= gy2_r;
    yn3_r <= yn2_r;
    yd3_r <= yd2_r;
  end

  always_ff @(posedge clk) begin
    item_r.yaw_num <= yn3_r;
    item_r.yaw_den <= yd3_r;
    item_r.gx      <= gx3_r;
    item_r.gy      <= gy3_r;
    item_r.sum_p   <= sqy_r + sqz_r;
    item_r.sum_r   <= sqx_r + sqz_r;
  end

  always_comb begin
    inflight = '0;
    for (int k = 0; k < FRONT_LAT; k++) begin
      inflight = inflight + FRONT_CNT_W'(v_r[k]);
    end
  end

  assign push = v_r[FRONT_LAT-1];
  assign item = item_r;

endmodule

// ===== design/qypr_queue.sv =====
// short queue between the front and the back parts
// depends on qypr_pkg; flop storage, read data straight from the head entry
module qypr_queue import qypr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qitem_t             push_item,
  input  logic               pop,
  output qitem_t             head_item,
  output logic               not_empty,
  output logic [Q_CNT_W-1:0] count
);

  qitem_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < Q_CNT_W'(Q_DEPTH))) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0)) else $error("pop from empty queue");

endmodule

// ===== design/qypr_isqrt.sv =====
// pipelined floor integer square root, one root bit per stage
// depends on qypr_pkg; ROOT_W stages, all advance together on en
module qypr_isqrt import qypr_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   n,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int TR_W  = REM_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SQ_W-1:0]   n_r    [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   n_in;
    logic [TR_W-1:0]   cur, trial;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign n_in    = n_r[s-1];
    end

    // bring down the next pair of bits and try root*4+1
    assign cur   = {rem_in, n_in[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[s]  <= REM_W'(cur - trial);
          root_r[s] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[s]  <= cur[REM_W-1:0];
          root_r[s] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        n_r[s] <= n_in << 2;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// ===== design/qypr_cordic.sv =====
// vectoring cordic giving atan2(num, den) in q3.13, saturated
// depends on qypr_pkg; one set-up stage then CORDIC_STAGES stages, advance on en
module qypr_cordic import qypr_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    yaw_mode,   // limit to pi, else to pi/2
  input  logic signed [OP_W-1:0]  num,
  input  logic signed [OP_W-1:0]  den,
  output logic signed [YAW_W-1:0] angle
);

  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic                    special;
    logic signed [YAW_W-1:0] sval;
  } cst_t;

  cst_t st_r [CORDIC_STAGES+1];
  cst_t prep;

  always_comb begin
    prep.special = (den == '0) || (num == '0);
    if (den == '0) begin
      if (num > 0) begin
        prep.sval = HALF_PI_Q13;
      end else if (num < 0) begin
        prep.sval = -HALF_PI_Q13;
      end else begin
        prep.sval = '0;
      end
    end else begin
      prep.sval = (den > 0) ? '0 : PI_Q13;
    end
    // left half plane: turn by pi, offset follows the numerator's sign
    if (den[OP_W-1]) begin
      prep.x = -XW'(den);
      prep.y = -XW'(num);
      prep.z = (num > 0) ? PI_Q30 : -PI_Q30;
    end else begin
      prep.x = XW'(den);
      prep.y = XW'(num);
      prep.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= prep;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    cst_t nxt;

    always_comb begin
      nxt = st_r[i];
      if (!st_r[i].y[XW-1]) begin
        nxt.x = st_r[i].x + (st_r[i].y >>> i);
        nxt.y = st_r[i].y - (st_r[i].x >>> i);
        nxt.z = st_r[i].z + ATAN_Q30[i];
      end else begin
        nxt.x = st_r[i].x - (st_r[i].y >>> i);
        nxt.y = st_r[i].y + (st_r[i].x >>> i);
        nxt.z = st_r[i].z - ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1] <= nxt;
      end
    end
  end

  logic signed [ZW-1:0] z_rnd, lim;

  always_comb begin
    z_rnd = (st_r[CORDIC_STAGES].z + ROUND_BIAS) >>> ANG_SHIFT;
    lim   = yaw_mode ? ZW'(PI_Q13) : ZW'(HALF_PI_Q13);
    if (st_r[CORDIC_STAGES].special) begin
      angle = st_r[CORDIC_STAGES].sval;
    end else if (z_rnd > lim) begin
      angle = YAW_W'(lim);
    end else if (z_rnd < -lim) begin
      angle = YAW_W'(-lim);
    end else begin
      angle = YAW_W'(z_rnd);
    end
  end

endmodule

// ===== design/quaternion_to_yaw_pitch_roll_core.sv =====
// quaternion to yaw, pitch and roll: one item per cycle sustained
// while out_tready does not stall the output register
// front: 4 stages into an 8-entry queue; back: 32-stage square root, cordic, output register
// the back stalls as a whole while the output register waits; the queue keeps the input open
// synchronous active-low reset clears valid bits, queue pointers and the output valid
module quaternion_to_yaw_pitch_roll_core import qypr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // yaw_angle (16), pitch_angle (15), roll_angle (15), zero pad
);

  localparam int BACK_LAT = ROOT_W + CORDIC_STAGES + 1;

  typedef struct packed {
    logic signed [OP_W-1:0] yaw_num;
    logic signed [OP_W-1:0] yaw_den;
    logic signed [G_W-1:0]  gx;
    logic signed [G_W-1:0]  gy;
  } side_t;

  logic signed [IN_W-1:0]  quat_w, quat_x, quat_y, quat_z;
  logic                    in_acc, f_push, q_nonempty, pop, en_b;
  qitem_t                  f_item, q_item;
  logic [FRONT_CNT_W-1:0]  f_inflight;
  logic [Q_CNT_W-1:0]      q_count;
  logic [Q_CNT_W:0]        credit;
  logic [ROOT_W-1:0]       root_p, root_r;
  side_t                   side_r [ROOT_W];
  logic [BACK_LAT-1:0]     bv_r;
  logic signed [YAW_W-1:0] yaw_a, pitch_a, roll_a;
  logic                    out_tvalid_r;
  logic signed [YAW_W-1:0] yaw_r;
  logic signed [PR_W-1:0]  pitch_r, roll_r;

  assign quat_w = in_tdata[15:0];
  assign quat_x = in_tdata[31:16];
  assign quat_y = in_tdata[47:32];
  assign quat_z = in_tdata[63:48];

  // room is reserved for every item already in the front stages
  assign credit    = (Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(f_inflight);
  assign in_tready = (credit < (Q_CNT_W+1)'(Q_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  qypr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .push     (f_push),
    .item     (f_item),
    .inflight (f_inflight)
  );

  qypr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (pop),
    .head_item (q_item),
    .not_empty (q_nonempty),
    .count     (q_count)
  );

  assign en_b = !out_tvalid_r || out_tready;
  assign pop  = en_b && q_nonempty;

  qypr_isqrt u_sqrt_p (
    .clk  (clk),
    .en   (en_b),
    .n    (q_item.sum_p),
    .root (root_p)
  );

  qypr_isqrt u_sqrt_r (
    .clk  (clk),
    .en   (en_b),
    .n    (q_item.sum_r),
    .root (root_r)
  );

  // operands that wait beside the square roots
  always_ff @(posedge clk) begin
    if (en_b) begin
      side_r[0].yaw_num <= q_item.yaw_num;
      side_r[0].yaw_den <= q_item.yaw_den;
      side_r[0].gx      <= q_item.gx;
      side_r[0].gy      <= q_item.gy;
      for (int k = 1; k < ROOT_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  qypr_cordic u_cordic_yaw (
    .clk      (clk),
    .en       (en_b),
    .yaw_mode (1'b1),
    .num      (side_r[ROOT_W-1].yaw_num),
    .den      (side_r[ROOT_W-1].yaw_den),
    .angle    (yaw_a)
  );

  qypr_cordic u_cordic_pitch (
    .clk      (clk),
    .en       (en_b),
    .yaw_mode (1'b0),
    .num      (OP_W'(side_r[ROOT_W-1].gx)),
    .den      (OP_W'(root_p)),
    .angle    (pitch_a)
  );

  qypr_cordic u_cordic_roll (
    .clk      (clk),
    .en       (en_b),
    .yaw_mode (1'b0),
    .num      (OP_W'(side_r[ROOT_W-1].gy)),
    .den      (OP_W'(root_r)),
    .angle    (roll_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en_b) begin
      bv_r         <= {bv_r[BACK_LAT-2:0], q_nonempty};
      out_tvalid_r <= bv_r[BACK_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      yaw_r   <= yaw_a;
      pitch_r <= pitch_a[PR_W-1:0];
      roll_r  <= roll_a[PR_W-1:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, roll_r, pitch_r, yaw_r};

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= (Q_CNT_W+1)'(Q_DEPTH)) else $error("front and queue hold more than the depth");

  a_back_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(bv_r)) else $error("back moved while stalled");

endmodule
